FILE: hw/rtl/radial_undistort_point_macros.svh
// ---------------------------------------------------------------------------
// radial undistort point assertion macros
// assertion forms for the checker file
// ---------------------------------------------------------------------------
`ifndef RADIAL_UNDISTORT_POINT_MACROS_SVH
`define RADIAL_UNDISTORT_POINT_MACROS_SVH

// checked while out of reset
`define RUP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("radial undistort point check failed");

// checked on every edge, reset included
`define RUP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("radial undistort point reset check failed");

`endif

FILE: hw/rtl/rup_pkg.sv
// ---------------------------------------------------------------------------
// rup_pkg
// shared constants and types of the radial undistortion pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package rup_pkg;

  localparam int ITERATIONS = 11;
  localparam int FRAC_BITS  = 20;
  localparam int OUT_FRAC   = 22;
  localparam int DATA_W     = 24;
  localparam int Z_W        = 23;

  localparam logic [30:0] R_MAX = 31'h7FFFFFFF;

  typedef enum logic {
    RUP_REG_K1 = 1'b0,
    RUP_REG_K2 = 1'b1
  } rup_reg_t;

  // point estimate passed between iterations
  typedef struct packed {
    logic               valid;
    logic signed [23:0] xd;
    logic signed [23:0] yd;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               bad;
  } rup_pt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rup_iter.sv
// ---------------------------------------------------------------------------
// rup_iter
// one fixed-point iteration: radius, distortion factor, two pipelined dividers
// ---------------------------------------------------------------------------
`default_nettype none

module rup_iter (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic signed [23:0] k1,
  input  logic signed [23:0] k2,
  input  rup_pkg::rup_pt_t   pt_in,
  output rup_pkg::rup_pt_t   pt_out
);

  localparam int STEPS = rup_pkg::DATA_W;
  localparam int FW    = rup_pkg::FRAC_BITS;

  typedef struct packed {
    logic               valid;
    logic signed [23:0] xd;
    logic signed [23:0] yd;
    logic               bad;
  } ctl_t;

  typedef struct packed {
    ctl_t        c;
    logic [46:0] sqx;
    logic [46:0] sqy;
  } sa_t;

  typedef struct packed {
    ctl_t        c;
    logic [27:0] r2;
  } sb_t;

  typedef struct packed {
    ctl_t               c;
    logic [55:0]        rr;
    logic signed [52:0] m1;
  } sc_t;

  typedef struct packed {
    ctl_t               c;
    logic [30:0]        r4;
    logic signed [32:0] t1;
  } sd_t;

  typedef struct packed {
    ctl_t               c;
    logic signed [55:0] m2;
    logic signed [32:0] t1;
  } se_t;

  typedef struct packed {
    ctl_t        c;
    logic [34:0] factor;
  } sf_t;

  typedef struct packed {
    ctl_t              c;
    logic [34:0]       factor;
    logic [1:0]        ovf;
    logic [1:0][3:0]   lo;
    logic [1:0][35:0]  rem;
    logic [1:0][23:0]  q;
  } dv_t;

  sa_t sa, sa_next;
  sb_t sb, sb_next;
  sc_t sc, sc_next;
  sd_t sd, sd_next;
  se_t se, se_next;
  sf_t sf, sf_next;
  dv_t dv [0:STEPS];
  dv_t dv0_next;
  rup_pkg::rup_pt_t pt_next;

  logic signed [47:0] px;
  logic signed [47:0] py;
  logic [47:0]        sum2;
  logic signed [37:0] fs;
  logic               bad_f;
  logic [1:0][23:0]   mag;
  logic [1:0]         neg;
  logic [1:0][23:0]   lim;
  logic [1:0][23:0]   mm;
  logic [1:0][23:0]   res;

  // squares
  always_comb begin
    px = pt_in.x * pt_in.x;
    py = pt_in.y * pt_in.y;
    sa_next.c.valid = pt_in.valid;
    sa_next.c.xd    = pt_in.xd;
    sa_next.c.yd    = pt_in.yd;
    sa_next.c.bad   = pt_in.bad;
    sa_next.sqx     = px[46:0];
    sa_next.sqy     = py[46:0];
  end

  // r2
  always_comb begin
    sum2       = {1'b0, sa.sqx} + {1'b0, sa.sqy};
    sb_next.c  = sa.c;
    sb_next.r2 = sum2[47:FW];
  end

  // r2 squared and k1 term
  always_comb begin
    sc_next.c  = sb.c;
    sc_next.rr = sb.r2 * sb.r2;
    sc_next.m1 = k1 * $signed({1'b0, sb.r2});
  end

  // r4 saturation
  always_comb begin
    sd_next.c  = sc.c;
    sd_next.r4 = (|sc.rr[55:51]) ? rup_pkg::R_MAX : sc.rr[50:FW];
    sd_next.t1 = $signed(sc.m1[52:FW]);
  end

  // k2 term
  always_comb begin
    se_next.c  = sd.c;
    se_next.m2 = k2 * $signed({1'b0, sd.r4});
    se_next.t1 = sd.t1;
  end

  // factor, clamped to one lsb when not positive
  always_comb begin
    fs = (38'sd1 <<< FW) + 38'($signed(se.t1)) + 38'($signed(se.m2[55:FW]));
    bad_f          = fs[37] || (fs == '0);
    sf_next.c      = se.c;
    sf_next.c.bad  = se.c.bad | bad_f;
    sf_next.factor = bad_f ? 35'd1 : fs[34:0];
  end

  // divider setup
  always_comb begin
    mag[0] = sf.c.xd[23] ? 24'(-sf.c.xd) : 24'(sf.c.xd);
    mag[1] = sf.c.yd[23] ? 24'(-sf.c.yd) : 24'(sf.c.yd);
    dv0_next.c      = sf.c;
    dv0_next.factor = sf.factor;
    for (int i = 0; i < 2; i++) begin
      dv0_next.ovf[i] = {15'd0, mag[i][23:4]} >= sf.factor;
      dv0_next.lo[i]  = mag[i][3:0];
      dv0_next.rem[i] = {16'd0, mag[i][23:4]};
      dv0_next.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.c.valid    <= 1'b0;
      sb.c.valid    <= 1'b0;
      sc.c.valid    <= 1'b0;
      sd.c.valid    <= 1'b0;
      se.c.valid    <= 1'b0;
      sf.c.valid    <= 1'b0;
      dv[0].c.valid <= 1'b0;
    end else if (en) begin
      sa    <= sa_next;
      sb    <= sb_next;
      sc    <= sc_next;
      sd    <= sd_next;
      se    <= se_next;
      sf    <= sf_next;
      dv[0] <= dv0_next;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int B = STEPS - 1 - j;
    logic [1:0]       din;
    logic [1:0][36:0] sh;
    dv_t              nx;

    if (B >= FW) begin : g_bit
      assign din = {dv[j].lo[1][B-FW], dv[j].lo[0][B-FW]};
    end else begin : g_zero
      assign din = 2'b00;
    end

    always_comb begin
      nx = dv[j];
      for (int i = 0; i < 2; i++) begin
        sh[i] = {dv[j].rem[i], din[i]};
        if (sh[i] >= {2'b00, dv[j].factor}) begin
          nx.rem[i] = 36'(sh[i] - {2'b00, dv[j].factor});
          nx.q[i]   = {dv[j].q[i][22:0], 1'b1};
        end else begin
          nx.rem[i] = sh[i][35:0];
          nx.q[i]   = {dv[j].q[i][22:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].c.valid <= 1'b0;
      end else if (en) begin
        dv[j+1] <= nx;
      end
    end
  end

  // sign and 24-bit saturation
  always_comb begin
    neg[0] = dv[STEPS].c.xd[23];
    neg[1] = dv[STEPS].c.yd[23];
    for (int i = 0; i < 2; i++) begin
      lim[i] = neg[i] ? 24'h800000 : 24'h7FFFFF;
      mm[i]  = (dv[STEPS].ovf[i] || (dv[STEPS].q[i] > lim[i])) ? lim[i] : dv[STEPS].q[i];
      res[i] = neg[i] ? 24'(-mm[i]) : mm[i];
    end
    pt_next.valid = dv[STEPS].c.valid;
    pt_next.xd    = dv[STEPS].c.xd;
    pt_next.yd    = dv[STEPS].c.yd;
    pt_next.x     = $signed(res[0]);
    pt_next.y     = $signed(res[1]);
    pt_next.bad   = dv[STEPS].c.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_out.valid <= 1'b0;
    end else if (en) begin
      pt_out <= pt_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/radial_undistort_point.sv
// ---------------------------------------------------------------------------
// radial_undistort_point
// inverse two-coefficient radial distortion and unit ray of one point
// ---------------------------------------------------------------------------
//  channel | dir | handshake        | content
//  s_*     | in  | tvalid / tready  | distorted point
//  m_*     | out | tvalid / tready  | unit ray and bad factor flag
//  apb     | in  | psel / penable   | k1 at 0x0, k2 at 0x4
//
//  one item per cycle while the output is not stalled
//  structure: 11 iterations of 32 stages, each with 24-stage restoring dividers,
//  then a 24-stage square root and 23-stage ray dividers
//  all stages share one enable; a stalled output holds the whole pipeline
//  synchronous reset clears valid bits and both coefficients
// ---------------------------------------------------------------------------
`default_nettype none

module radial_undistort_point (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // distorted_x, distorted_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // ray_x, ray_y, ray_z, zero pad
  output logic [0:0]  m_tuser,   // bad_factor
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IT    = rup_pkg::ITERATIONS;
  localparam int FW    = rup_pkg::FRAC_BITS;
  localparam int SQ_N  = rup_pkg::DATA_W;
  localparam int DV_N  = rup_pkg::Z_W;

  typedef struct packed {
    logic               valid;
    logic               bad;
    logic signed [23:0] x;
    logic signed [23:0] y;
  } nc_t;

  typedef struct packed {
    nc_t         c;
    logic [46:0] sqx;
    logic [46:0] sqy;
  } na_t;

  typedef struct packed {
    nc_t         c;
    logic [47:0] n;
    logic [24:0] rem;
    logic [23:0] root;
  } sq_t;

  typedef struct packed {
    nc_t              c;
    logic [23:0]      norm;
    logic [2:0]       ovf;
    logic [2:0]       lsb;
    logic [2:0][23:0] rem;
    logic [2:0][22:0] q;
  } rs_t;

  logic signed [23:0] k1;
  logic signed [23:0] k2;
  logic               en;
  logic               out_valid;
  logic [23:0]        ray_x;
  logic [23:0]        ray_y;
  logic [22:0]        ray_z;
  logic               bad_factor;

  rup_pkg::rup_pt_t pt [0:IT];

  na_t na, na_next;
  sq_t sq [0:SQ_N];
  sq_t sq0_next;
  rs_t rs [0:DV_N];
  rs_t rs0_next;

  logic signed [47:0] px;
  logic signed [47:0] py;
  logic [2:0][23:0]   mag;
  logic [22:0]        lim_q;
  logic [2:0][22:0]   qq;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0;
      k2 <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (rup_pkg::rup_reg_t'(paddr[2]))
        rup_pkg::RUP_REG_K1: k1 <= $signed(pwdata[23:0]);
        rup_pkg::RUP_REG_K2: k2 <= $signed(pwdata[23:0]);
        default:             k1 <= k1;
      endcase
    end
  end

  always_comb begin
    unique case (rup_pkg::rup_reg_t'(paddr[2]))
      rup_pkg::RUP_REG_K1: prdata = 32'(k1);
      rup_pkg::RUP_REG_K2: prdata = 32'(k2);
      default:             prdata = '0;
    endcase
  end

  // pipeline enable
  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  always_comb begin
    pt[0].valid = s_tvalid;
    pt[0].xd    = $signed(s_tdata[23:0]);
    pt[0].yd    = $signed(s_tdata[47:24]);
    pt[0].x     = $signed(s_tdata[23:0]);
    pt[0].y     = $signed(s_tdata[47:24]);
    pt[0].bad   = 1'b0;
  end

  for (genvar i = 0; i < IT; i++) begin : g_iter
    rup_iter u_iter (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .k1     (k1),
      .k2     (k2),
      .pt_in  (pt[i]),
      .pt_out (pt[i+1])
    );
  end

  // squared length of (x, y, 1)
  always_comb begin
    px = pt[IT].x * pt[IT].x;
    py = pt[IT].y * pt[IT].y;
    na_next.c.valid = pt[IT].valid;
    na_next.c.bad   = pt[IT].bad;
    na_next.c.x     = pt[IT].x;
    na_next.c.y     = pt[IT].y;
    na_next.sqx     = px[46:0];
    na_next.sqy     = py[46:0];
  end

  always_comb begin
    sq0_next.c    = na.c;
    sq0_next.n    = {1'b0, na.sqx} + {1'b0, na.sqy} + (48'd1 << (2 * FW));
    sq0_next.rem  = '0;
    sq0_next.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      na.c.valid    <= 1'b0;
      sq[0].c.valid <= 1'b0;
    end else if (en) begin
      na    <= na_next;
      sq[0] <= sq0_next;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam int HB = 47 - 2 * k;
    logic [26:0] sh;
    logic [25:0] trial;
    sq_t         nx;

    always_comb begin
      nx    = sq[k];
      sh    = {sq[k].rem, sq[k].n[HB -: 2]};
      trial = {sq[k].root, 2'b01};
      if (sh >= {1'b0, trial}) begin
        nx.rem  = 25'(sh - {1'b0, trial});
        nx.root = {sq[k].root[22:0], 1'b1};
      end else begin
        nx.rem  = sh[24:0];
        nx.root = {sq[k].root[22:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].c.valid <= 1'b0;
      end else if (en) begin
        sq[k+1] <= nx;
      end
    end
  end

  // ray divider setup
  always_comb begin
    mag[0] = sq[SQ_N].c.x[23] ? 24'(-sq[SQ_N].c.x) : 24'(sq[SQ_N].c.x);
    mag[1] = sq[SQ_N].c.y[23] ? 24'(-sq[SQ_N].c.y) : 24'(sq[SQ_N].c.y);
    mag[2] = 24'd1 << FW;
    rs0_next.c    = sq[SQ_N].c;
    rs0_next.norm = sq[SQ_N].root;
    for (int i = 0; i < 3; i++) begin
      rs0_next.ovf[i] = {1'b0, mag[i][23:1]} >= sq[SQ_N].root;
      rs0_next.lsb[i] = mag[i][0];
      rs0_next.rem[i] = {1'b0, mag[i][23:1]};
      rs0_next.q[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs[0].c.valid <= 1'b0;
    end else if (en) begin
      rs[0] <= rs0_next;
    end
  end

  for (genvar j = 0; j < DV_N; j++) begin : g_div
    logic [2:0]       din;
    logic [2:0][24:0] sh;
    rs_t              nx;

    if (j == 0) begin : g_bit
      assign din = rs[j].lsb;
    end else begin : g_zero
      assign din = 3'b000;
    end

    always_comb begin
      nx = rs[j];
      for (int i = 0; i < 3; i++) begin
        sh[i] = {rs[j].rem[i], din[i]};
        if (sh[i] >= {1'b0, rs[j].norm}) begin
          nx.rem[i] = 24'(sh[i] - {1'b0, rs[j].norm});
          nx.q[i]   = {rs[j].q[i][21:0], 1'b1};
        end else begin
          nx.rem[i] = sh[i][23:0];
          nx.q[i]   = {rs[j].q[i][21:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rs[j+1].c.valid <= 1'b0;
      end else if (en) begin
        rs[j+1] <= nx;
      end
    end
  end

  // clamp to one and apply sign
  always_comb begin
    lim_q = 23'd1 << rup_pkg::OUT_FRAC;
    for (int i = 0; i < 3; i++) begin
      qq[i] = (rs[DV_N].ovf[i] || (rs[DV_N].q[i] > lim_q)) ? lim_q : rs[DV_N].q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= rs[DV_N].c.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray_x      <= rs[DV_N].c.x[23] ? 24'(-{1'b0, qq[0]}) : {1'b0, qq[0]};
      ray_y      <= rs[DV_N].c.y[23] ? 24'(-{1'b0, qq[1]}) : {1'b0, qq[1]};
      ray_z      <= qq[2];
      bad_factor <= rs[DV_N].c.bad;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, ray_z, ray_y, ray_x};
  assign m_tuser  = bad_factor;

endmodule

`default_nettype wire

FILE: hw/rtl/rup_chk.sv
// ---------------------------------------------------------------------------
// rup_chk
// port-level checks of the radial undistortion block, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "radial_undistort_point_macros.svh"

module rup_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  `RUP_ASSERT_RST(a_rst_clears, rst |=> !m_tvalid)
  `RUP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `RUP_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready))
  `RUP_ASSERT(a_z_range, m_tvalid |-> (m_tdata[70:48] <= 23'h400000) && (m_tdata[70:48] != '0))
  `RUP_ASSERT(a_x_range, m_tvalid && m_tdata[23] |-> m_tdata[23:0] >= 24'hC00000)

endmodule

bind radial_undistort_point rup_chk u_rup_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
